/* rtl/event_packet_deframer_assert.svh */
// Assertion macros for the event packet deframer.
`ifndef EVENT_PACKET_DEFRAMER_ASSERT_SVH
`define EVENT_PACKET_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF

`define EPD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("deframer assertion failed");

`define EPD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define EPD_ASSERT(name, prop)

`define EPD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* rtl/epd_pkg.sv */
// Types and constants shared by the event packet deframer.
package epd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TimeW = 32;
  localparam int unsigned PosW  = 3;

  localparam logic [PosW-1:0] HdrBytes = 3'd4;
  localparam logic [PosW-1:0] RecBytes = 3'd5;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusShortHdr = 2'd1,
    StatusPartial  = 2'd2
  } end_status_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             is_final;
  } in_t;

  typedef struct packed {
    logic             event_valid;
    logic [6:0]       event_id;
    logic             event_parity;
    logic [ByteW-1:0] event_x;
    logic [ByteW-1:0] event_y;
    logic [TimeW:0]   event_time;
    logic             message_end;
    end_status_e      end_status;
  } out_t;

endpackage

/* rtl/event_packet_deframer.sv */
// Event packet deframer: splits a byte stream into a timestamp header and event records.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one message byte per transaction, with
// is_final set on the last byte of the message. The first four bytes give a big-endian
// base timestamp; every following five bytes give one event record.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transaction for each byte that
// completes a record or ends the message. An event carries id, parity, x, y and the base
// plus the record's 16-bit offset; a message end carries a status (ok, short header or
// partial record). A final byte that completes a record gives one transaction with both.
// Bytes that do neither produce nothing.
// Throughput: one byte per cycle while the receiver does not stall. A byte taken passes
// through the input register and the decode logic into the result register before its
// result is on the output.
// When the receiver stalls, the result register holds and the input register keeps taking
// bytes that give no result; the input stalls once the byte it holds has a result to give.
// Reset empties both registers and returns the deframer to header collection.
module event_packet_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  epd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output epd_pkg::out_t out_data_o
);
  import epd_pkg::*;

  logic             s1_valid_q;
  in_t              s1_data_q;
  logic             s1_fire;
  logic             out_free;
  logic             produces;

  logic [TimeW-1:0] base_q, base_d;
  logic             hdr_q, hdr_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [TimeW-1:0] rec_q, rec_d;
  logic [PosW-1:0]  pos_inc;
  logic             hdr_upd;
  logic [PosW-1:0]  pos_upd;
  logic [15:0]      offset;

  logic             out_valid_q;
  out_t             out_data_q;
  out_t             res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!produces || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  assign pos_inc = pos_q + 3'd1;
  assign offset  = {rec_q[ByteW-1:0], s1_data_q.in_byte};

  always_comb begin
    base_d  = base_q;
    hdr_upd = hdr_q;
    pos_upd = pos_q;
    rec_d   = rec_q;
    res     = '0;
    if (hdr_q) begin
      base_d  = {base_q[TimeW-ByteW-1:0], s1_data_q.in_byte};
      pos_upd = pos_inc;
      if (pos_inc >= HdrBytes) begin
        hdr_upd = 1'b0;
        pos_upd = '0;
      end
    end else if (pos_q < RecBytes - 3'd1) begin
      rec_d   = {rec_q[TimeW-ByteW-1:0], s1_data_q.in_byte};
      pos_upd = pos_inc;
    end else begin
      res.event_valid  = 1'b1;
      res.event_id     = rec_q[31:25];
      res.event_parity = rec_q[24];
      res.event_x      = rec_q[23:16];
      res.event_y      = rec_q[15:8];
      res.event_time   = {1'b0, base_q} + {{(TimeW-15){1'b0}}, offset};
      pos_upd          = '0;
    end
    hdr_d = hdr_upd;
    pos_d = pos_upd;
    if (s1_data_q.is_final) begin
      res.message_end = 1'b1;
      if (hdr_upd) begin
        res.end_status = StatusShortHdr;
      end else if (pos_upd != '0) begin
        res.end_status = StatusPartial;
      end else begin
        res.end_status = StatusOk;
      end
      // return to header collection
      base_d = '0;
      hdr_d  = 1'b1;
      pos_d  = '0;
    end
    produces = res.event_valid || s1_data_q.is_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      hdr_q  <= 1'b1;
      pos_q  <= '0;
    end else if (s1_fire) begin
      base_q <= base_d;
      hdr_q  <= hdr_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && produces) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && produces) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "event_packet_deframer_assert.svh"

  `EPD_ASSERT(a_result_not_empty,
    !out_valid_o || out_data_o.event_valid || out_data_o.message_end)
  `EPD_ASSERT(a_event_status_ok,
    !(out_valid_o && out_data_o.event_valid) || out_data_o.end_status == StatusOk)
  `EPD_ASSERT(a_hdr_pos_bound, !hdr_q || pos_q < HdrBytes)
  `EPD_ASSERT(a_rec_pos_bound, hdr_q || pos_q < RecBytes)
  `EPD_ASSERT_NEXT(a_final_clears, s1_fire && s1_data_q.is_final,
    hdr_q && pos_q == '0 && base_q == '0)
  `EPD_ASSERT_NEXT(a_result_loaded, s1_fire && produces, out_valid_q)

endmodule

/* tb/epd_record_checker.sv */
// Checker for the event packet deframer: predicts each record and end status, compares results.
module epd_record_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  epd_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  epd_pkg::out_t out_data_i,
  output int            errors_o = 0,
  output int            pending_o = 0
);
  import epd_pkg::*;

  logic [TimeW-1:0] base_ts;
  logic             collecting_hdr;
  logic [PosW-1:0]  byte_cnt;
  logic [31:0]      rec_shift;
  out_t             awaited_records[$];
  out_t             want;

  function automatic void clear_decoder();
    base_ts        = '0;
    collecting_hdr = 1'b1;
    byte_cnt       = '0;
    rec_shift      = '0;
  endfunction

  function automatic void decode_byte(input in_t t);
    out_t        r;
    logic        got_event;
    logic [15:0] offset;
    r         = '0;
    got_event = 1'b0;
    if (collecting_hdr) begin
      base_ts  = {base_ts[TimeW-9:0], t.in_byte};
      byte_cnt = byte_cnt + 3'd1;
      if (byte_cnt >= HdrBytes) begin
        collecting_hdr = 1'b0;
        byte_cnt       = '0;
      end
    end else if (byte_cnt < RecBytes - 3'd1) begin
      rec_shift = {rec_shift[23:0], t.in_byte};
      byte_cnt  = byte_cnt + 3'd1;
    end else begin
      offset         = {rec_shift[7:0], t.in_byte};
      got_event      = 1'b1;
      r.event_valid  = 1'b1;
      r.event_id     = rec_shift[31:25];
      r.event_parity = rec_shift[24];
      r.event_x      = rec_shift[23:16];
      r.event_y      = rec_shift[15:8];
      r.event_time   = {1'b0, base_ts} + {17'd0, offset};
      byte_cnt       = '0;
    end
    if (t.is_final) begin
      r.message_end = 1'b1;
      if (collecting_hdr) begin
        r.end_status = StatusShortHdr;
      end else if (byte_cnt != '0) begin
        r.end_status = StatusPartial;
      end else begin
        r.end_status = StatusOk;
      end
      clear_decoder();
    end
    if (got_event || t.is_final) begin
      awaited_records = {awaited_records, r};
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_decoder();
      awaited_records.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_records.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errors_o++;
        end else begin
          want = awaited_records.pop_front();
          check_field("event_valid", 64'(want.event_valid), 64'(out_data_i.event_valid));
          check_field("event_id", 64'(want.event_id), 64'(out_data_i.event_id));
          check_field("event_parity", 64'(want.event_parity), 64'(out_data_i.event_parity));
          check_field("event_x", 64'(want.event_x), 64'(out_data_i.event_x));
          check_field("event_y", 64'(want.event_y), 64'(out_data_i.event_y));
          check_field("event_time", 64'(want.event_time), 64'(out_data_i.event_time));
          check_field("message_end", 64'(want.message_end), 64'(out_data_i.message_end));
          check_field("end_status", 64'(want.end_status), 64'(out_data_i.end_status));
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_data_i);
      end
      pending_o = awaited_records.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the event packet deframer testbench: clock, reset, message stimulus and verdict.
module testbench;
  import epd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   errors;
  int   pending;

  int   bytes_taken = 0;
  int   burst_left = 0;
  int   hold_left = 0;
  int   free_left = 0;
  int   ready_roll;
  bit   long_hold_done = 1'b0;
  bit   drain_pause_done = 1'b0;

  always #10 clk = ~clk;

  event_packet_deframer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  epd_record_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // hold off the receiver once for a long stretch while bytes keep coming; otherwise drive ready at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      free_left = 0;
    end else if (!long_hold_done && bytes_taken >= 300) begin
      long_hold_done = 1'b1;
      hold_left = 120;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      out_ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 2) begin
        hold_left = $urandom_range(15, 60);
        out_ready <= 1'b0;
      end else if (ready_roll < 6) begin
        free_left = $urandom_range(30, 150);
        out_ready <= 1'b1;
      end else begin
        out_ready <= (ready_roll % 4 != 0);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return 8'h00;
    end else if (roll == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    int roll;
    gap = 0;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
    end else if (bytes_taken >= 300 && bytes_taken < 500) begin
      gap = 0;
    end else if (roll < 4) begin
      burst_left = $urandom_range(30, 100);
    end else if (roll < 64) begin
      gap = 0;
    end else if (roll < 94) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, is_final: fin};
    do @(posedge clk); while (!in_ready);
    bytes_taken++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  task automatic send_random_message();
    logic [7:0] msg[$];
    int kind;
    int len;
    int nrec;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      len = $urandom_range(1, 15);
    end else if (kind < 12) begin
      len = $urandom_range(1, 3);
    end else begin
      nrec = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      len = 4 + 5 * nrec;
      if (kind < 28) begin
        len += $urandom_range(1, 4);
      end
    end
    repeat (len) msg = {msg, rand_byte()};
    send_message(msg);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [7:0] msg[$];
    int wait_cnt;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    msg = {8'hFF};
    send_message(msg);
    msg = {8'h00, 8'h80};
    send_message(msg);
    msg = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message(msg);
    msg = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message(msg);
    msg = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
    send_message(msg);
    in_valid <= 1'b0;
    wait_drained();

    while (bytes_taken < 1500) begin
      send_random_message();
      if (!drain_pause_done && bytes_taken >= 900) begin
        drain_pause_done = 1'b1;
        in_valid <= 1'b0;
        wait_drained();
      end
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
